// ----- src/ledseq_pkg.sv -----
// Shared types and constants for the LED indicator sequencer.
package ledseq_pkg;

    // Width of the saturating millisecond counter.
    localparam int TIME_BITS = 12;

    // Width of the timing configuration registers.
    localparam int CFG_TIME_W = 12;

    // Width of the flash count register.
    localparam int FLASH_W = 8;

    // Width of the blink counters.
    localparam int BLINK_W = 7;

    // Common width used to compare the counter against a timing register.
    localparam int CMP_W = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;

    // Largest number of start blinks that runs a sequence.
    localparam logic [FLASH_W-1:0] MAX_BLINKS = FLASH_W'(64);

    // Width of the configuration data and index.
    localparam int CFG_DATA_W = CFG_TIME_W;
    localparam int CFG_IDX_W = 3;

    // Saturation value of the millisecond counter.
    localparam logic [TIME_BITS-1:0] TICK_MAX = {TIME_BITS{1'b1}};

    // Operating modes, densely numbered from idle.
    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_INIT      = 4'd1,
        M_SEQ_START = 4'd2,
        M_OFF_PHASE = 4'd3,
        M_ON_PHASE  = 4'd4,
        M_LOCK      = 4'd5,
        M_LOCK_SUC  = 4'd6,
        M_SUC_HOLD  = 4'd7,
        M_UNLOCK    = 4'd8,
        M_NOKEY     = 4'd9,
        M_END       = 4'd10
    } mode_t;

    // Mode command codes.
    typedef enum logic [2:0] {
        CMD_START    = 3'd0,
        CMD_END      = 3'd1,
        CMD_LOCK     = 3'd2,
        CMD_LOCK_SUC = 3'd3,
        CMD_UNLOCK   = 3'd4,
        CMD_NOKEY    = 3'd5
    } cmd_t;

    // Kinds of input transaction.
    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLASH_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_TIME     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ON_TIME      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_PER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOKEY_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SUC_HOLD     = 3'd6;

endpackage

// ----- src/led_indicator_sequencer_core.sv -----
// LED indicator sequencer: mode state machine driving green and red LEDs.
//
//  Channel   Direction  Signals                          Content
//  s_*       in         s_tvalid s_tready s_tdata s_tuser tick or mode command
//  m_*       out        m_tvalid m_tready m_tdata         LED levels, done, mode
//  cfg_*     in         cfg_we cfg_index cfg_data          timing registers
//
// Each input transaction is handled at its accepting edge: the mode register
// and the counters update and the result lands in the output register at
// that same edge. Sustained rate is one transaction per cycle while the output
// side takes results, set by the single output register. A result waiting in
// the output register is replaced in the same cycle that it is taken, so stalls
// on the output side only hold off the input while it is full and not taken.
// Reset is asynchronous and puts the block in idle with both LEDs off.
module led_indicator_sequencer_core
    import ledseq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [2:0] command, [3] system_ready
    input  logic                  s_tuser,   // [0] kind
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] green_on, [1] red_on,
                                             // [2] sequence_done, [6:3] mode_now
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [FLASH_W-1:0]    flash_count_reg;
    logic [CFG_TIME_W-1:0] off_time_reg;
    logic [CFG_TIME_W-1:0] on_time_reg;
    logic [CFG_TIME_W-1:0] lock_period_reg;
    logic [CFG_TIME_W-1:0] unlock_period_reg;
    logic [CFG_TIME_W-1:0] nokey_period_reg;
    logic [CFG_TIME_W-1:0] success_hold_reg;

    // Sequencer state
    mode_t                 mode_reg, mode_next;
    logic [TIME_BITS-1:0]  tick_count_reg, tick_count_next;
    logic [BLINK_W-1:0]    blinks_done_reg, blinks_done_next;
    logic [BLINK_W-1:0]    blink_target_reg, blink_target_next;
    logic                  green_reg, green_next;
    logic                  red_reg, red_next;

    // Output register
    logic                  out_valid_reg;
    logic [7:0]            out_data_reg;

    // Decoded input and helper values
    logic                  in_accept;
    cmd_t                  in_cmd;
    logic                  in_ready;
    logic                  in_kind;
    logic                  done_next;
    logic [TIME_BITS-1:0]  tick_inc;
    logic [CMP_W-1:0]      tick_cmp;
    logic                  flash_valid;
    logic [BLINK_W-1:0]    blinks_inc;

    assign in_kind   = s_tuser;
    assign in_cmd    = cmd_t'(s_tdata[2:0]);
    assign in_ready  = s_tdata[3];
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_count_reg   <= FLASH_W'(3);
            off_time_reg      <= CFG_TIME_W'(400);
            on_time_reg       <= CFG_TIME_W'(200);
            lock_period_reg   <= CFG_TIME_W'(100);
            unlock_period_reg <= CFG_TIME_W'(200);
            nokey_period_reg  <= CFG_TIME_W'(200);
            success_hold_reg  <= CFG_TIME_W'(2000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLASH_COUNT:  flash_count_reg   <= cfg_data[FLASH_W-1:0];
                REG_OFF_TIME:     off_time_reg      <= cfg_data;
                REG_ON_TIME:      on_time_reg       <= cfg_data;
                REG_LOCK_PERIOD:  lock_period_reg   <= cfg_data;
                REG_UNLOCK_PER:   unlock_period_reg <= cfg_data;
                REG_NOKEY_PERIOD: nokey_period_reg  <= cfg_data;
                REG_SUC_HOLD:     success_hold_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The counter advances with saturation before the mode is evaluated.
    assign tick_inc    = (tick_count_reg == TICK_MAX) ? tick_count_reg
                                                      : tick_count_reg + 1'b1;
    assign tick_cmp    = CMP_W'(tick_inc);
    assign flash_valid = (flash_count_reg != '0) && (flash_count_reg <= MAX_BLINKS);
    assign blinks_inc  = blinks_done_reg + 1'b1;

    // Next state. Passing modes (idle with ready, init, sequence start,
    // lock success) run through to the following waiting mode in one tick.
    always_comb
    begin
        mode_next         = mode_reg;
        tick_count_next   = tick_count_reg;
        blinks_done_next  = blinks_done_reg;
        blink_target_next = blink_target_reg;
        green_next        = green_reg;
        red_next          = red_reg;
        done_next         = 1'b0;

        if (in_kind == KIND_CMD)
        begin
            // A command only selects the mode; unknown codes are ignored.
            unique case (in_cmd)
                CMD_START:    mode_next = M_INIT;
                CMD_END:      mode_next = M_END;
                CMD_LOCK:     mode_next = M_LOCK;
                CMD_LOCK_SUC: mode_next = M_LOCK_SUC;
                CMD_UNLOCK:   mode_next = M_UNLOCK;
                CMD_NOKEY:    mode_next = M_NOKEY;
                default:      ;
            endcase
        end
        else
        begin
            tick_count_next = tick_inc;
            unique case (mode_reg) inside
                M_IDLE, M_INIT, M_SEQ_START:
                begin
                    if (mode_reg == M_SEQ_START)
                    begin
                        green_next       = 1'b0;
                        tick_count_next  = '0;
                        blinks_done_next = '0;
                        mode_next        = M_OFF_PHASE;
                    end
                    else if (mode_reg == M_INIT || in_ready)
                    begin
                        // Init clears both LEDs, then starts the blinks or ends.
                        green_next = 1'b0;
                        red_next   = 1'b0;
                        if (flash_valid)
                        begin
                            blink_target_next = flash_count_reg[BLINK_W-1:0];
                            tick_count_next   = '0;
                            blinks_done_next  = '0;
                            mode_next         = M_OFF_PHASE;
                        end
                        else
                        begin
                            mode_next = M_END;
                        end
                    end
                end
                M_OFF_PHASE:
                begin
                    if (tick_cmp > CMP_W'(off_time_reg))
                    begin
                        green_next      = 1'b1;
                        red_next        = 1'b1;
                        tick_count_next = '0;
                        mode_next       = M_ON_PHASE;
                    end
                end
                M_ON_PHASE:
                begin
                    if (tick_cmp > CMP_W'(on_time_reg))
                    begin
                        green_next       = 1'b0;
                        tick_count_next  = '0;
                        blinks_done_next = blinks_inc;
                        if (blinks_inc < blink_target_reg)
                        begin
                            mode_next = M_OFF_PHASE;
                        end
                        else
                        begin
                            done_next = 1'b1;
                            mode_next = M_END;
                        end
                    end
                end
                M_LOCK:
                begin
                    if (tick_cmp > CMP_W'(lock_period_reg))
                    begin
                        green_next      = !green_reg;
                        tick_count_next = '0;
                    end
                end
                M_LOCK_SUC:
                begin
                    green_next      = 1'b1;
                    tick_count_next = '0;
                    mode_next       = M_SUC_HOLD;
                end
                M_SUC_HOLD:
                begin
                    if (tick_cmp > CMP_W'(success_hold_reg))
                    begin
                        green_next = 1'b0;
                        mode_next  = M_END;
                    end
                end
                M_UNLOCK:
                begin
                    if (tick_cmp > CMP_W'(unlock_period_reg))
                    begin
                        green_next      = !green_reg;
                        tick_count_next = '0;
                    end
                end
                M_NOKEY:
                begin
                    if (tick_cmp > CMP_W'(nokey_period_reg))
                    begin
                        red_next        = !red_reg;
                        tick_count_next = '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers update on each accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= M_IDLE;
            tick_count_reg   <= '0;
            blinks_done_reg  <= '0;
            blink_target_reg <= '0;
            green_reg        <= 1'b0;
            red_reg          <= 1'b0;
        end
        else if (in_accept)
        begin
            mode_reg         <= mode_next;
            tick_count_reg   <= tick_count_next;
            blinks_done_reg  <= blinks_done_next;
            blink_target_reg <= blink_target_next;
            green_reg        <= green_next;
            red_reg          <= red_next;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, loaded with the state after the transaction.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= {1'b0, 4'(mode_next), done_next, red_next, green_next};
        end
    end

    // A completed start sequence is always reported together with end mode.
    a_done_in_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2]) |-> (m_tdata[6:3] == 4'(M_END)))
        else $error("sequence done reported outside end mode");

    // While blinking, the target is a valid count and not yet reached.
    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_OFF_PHASE || mode_reg == M_ON_PHASE) |->
        (blink_target_reg != '0 && BLINK_W'(64) >= blink_target_reg &&
         blinks_done_reg < blink_target_reg))
        else $error("blink counters out of range during start sequence");

    // Every accepted transaction leaves a result in the output register.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted transaction produced no result");

    // The result reports the mode that the state register now holds.
    a_mode_match: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (m_tdata[6:3] == 4'(mode_reg)))
        else $error("reported mode differs from mode register");

endmodule

// ----- tb/led_indicator_sequencer_core_test.sv -----
// Testbench for the LED indicator sequencer: stream stimulus, a mode predictor and a result check.
`timescale 1ns / 100ps

module led_indicator_sequencer_core_test;
    import ledseq_pkg::*;

    // Cycles with no transaction on either side before the run is declared hung.
    localparam int IDLE_LIMIT = 2000;
    localparam int REPORT_MAX = 10;

    // Index past the register list; the block ignores writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Command codes outside the defined set; the block ignores them.
    localparam logic [2:0] CMD_RSVD_LO = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [2:0] command;
        logic       system_ready;
    } led_request_t;

    typedef struct packed {
        logic       green_on;
        logic       red_on;
        logic       sequence_done;
        logic [3:0] mode_now;
    } led_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;   // [2:0] command, [3] system_ready
    logic                  s_tuser = 1'b0; // [0] kind
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;        // [0] green_on, [1] red_on,
                                           // [2] sequence_done, [6:3] mode_now
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predicted sequencer state and its copy of the registers.
    mode_t                 seq_mode = M_IDLE;
    logic [TIME_BITS-1:0]  ms_count = '0;
    logic [BLINK_W-1:0]    blinks_done = '0;
    logic [BLINK_W-1:0]    blink_target = '0;
    logic                  green_level = 1'b0;
    logic                  red_level = 1'b0;
    logic [FLASH_W-1:0]    flash_count_r = 8'd3;
    logic [CFG_TIME_W-1:0] off_time_r = 12'd400;
    logic [CFG_TIME_W-1:0] on_time_r = 12'd200;
    logic [CFG_TIME_W-1:0] lock_period_r = 12'd100;
    logic [CFG_TIME_W-1:0] unlock_period_r = 12'd200;
    logic [CFG_TIME_W-1:0] nokey_period_r = 12'd200;
    logic [CFG_TIME_W-1:0] hold_time_r = 12'd2000;

    led_request_t pending_requests[$];
    led_status_t  expected_status[$];
    led_request_t next_req;
    led_status_t  got_status;
    led_status_t  want_status;

    int send_gap = 0;
    int hold_cycles = 0;
    int stuck_cycles = 0;
    int seen_results = 0;
    int fail_count = 0;
    bit long_hold_done = 1'b0;
    bit no_idling = 1'b0;

    led_indicator_sequencer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one input transaction to the predicted state and returns the LED status.
    function automatic led_status_t sequencer_step(led_request_t req);
        led_status_t st;
        logic        done;
        logic        passing;
        int          guard;
        done = 1'b0;
        if (req.kind == KIND_CMD)
        begin
            case (req.command)
                CMD_START:    seq_mode = M_INIT;
                CMD_END:      seq_mode = M_END;
                CMD_LOCK:     seq_mode = M_LOCK;
                CMD_LOCK_SUC: seq_mode = M_LOCK_SUC;
                CMD_UNLOCK:   seq_mode = M_UNLOCK;
                CMD_NOKEY:    seq_mode = M_NOKEY;
                default:      ;
            endcase
        end
        else
        begin
            if (ms_count != TICK_MAX)
                ms_count = ms_count + 1'b1;
            // Passing modes fall through to the next mode within the same tick.
            passing = 1'b1;
            guard = 0;
            while (passing && guard < 5)
            begin
                guard++;
                passing = 1'b0;
                case (seq_mode)
                    M_IDLE:
                    begin
                        if (req.system_ready)
                        begin
                            seq_mode = M_INIT;
                            passing = 1'b1;
                        end
                    end
                    M_INIT:
                    begin
                        green_level = 1'b0;
                        red_level = 1'b0;
                        if (flash_count_r >= 1 && flash_count_r <= MAX_BLINKS)
                        begin
                            blink_target = flash_count_r[BLINK_W-1:0];
                            seq_mode = M_SEQ_START;
                        end
                        else
                            seq_mode = M_END;
                        passing = 1'b1;
                    end
                    M_SEQ_START:
                    begin
                        green_level = 1'b0;
                        ms_count = '0;
                        blinks_done = '0;
                        seq_mode = M_OFF_PHASE;
                        passing = 1'b1;
                    end
                    M_OFF_PHASE:
                    begin
                        if (ms_count > off_time_r)
                        begin
                            green_level = 1'b1;
                            red_level = 1'b1;
                            ms_count = '0;
                            seq_mode = M_ON_PHASE;
                        end
                    end
                    M_ON_PHASE:
                    begin
                        if (ms_count > on_time_r)
                        begin
                            green_level = 1'b0;
                            ms_count = '0;
                            blinks_done = blinks_done + 1'b1;
                            if (blinks_done < blink_target)
                                seq_mode = M_OFF_PHASE;
                            else
                            begin
                                done = 1'b1;
                                seq_mode = M_END;
                            end
                        end
                    end
                    M_LOCK:
                    begin
                        if (ms_count > lock_period_r)
                        begin
                            green_level = ~green_level;
                            ms_count = '0;
                        end
                    end
                    M_LOCK_SUC:
                    begin
                        green_level = 1'b1;
                        ms_count = '0;
                        seq_mode = M_SUC_HOLD;
                        passing = 1'b1;
                    end
                    M_SUC_HOLD:
                    begin
                        if (ms_count > hold_time_r)
                        begin
                            green_level = 1'b0;
                            seq_mode = M_END;
                        end
                    end
                    M_UNLOCK:
                    begin
                        if (ms_count > unlock_period_r)
                        begin
                            green_level = ~green_level;
                            ms_count = '0;
                        end
                    end
                    M_NOKEY:
                    begin
                        if (ms_count > nokey_period_r)
                        begin
                            red_level = ~red_level;
                            ms_count = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end
        st.green_on = green_level;
        st.red_on = red_level;
        st.sequence_done = done;
        st.mode_now = seq_mode;
        return st;
    endfunction

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int gap_length();
        int pick;
        if (no_idling)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_tick(input logic ready);
        led_request_t req;
        req.kind = KIND_TICK;
        req.command = 3'($urandom_range(0, 7));
        req.system_ready = ready;
        pending_requests.push_back(req);
    endfunction

    function automatic void add_command(input logic [2:0] code, input logic ready);
        led_request_t req;
        req.kind = KIND_CMD;
        req.command = code;
        req.system_ready = ready;
        pending_requests.push_back(req);
    endfunction

    // Writes one register and updates the predictor's copy; only used while the block is idle.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_FLASH_COUNT:  flash_count_r = value[FLASH_W-1:0];
            REG_OFF_TIME:     off_time_r = value;
            REG_ON_TIME:      on_time_r = value;
            REG_LOCK_PERIOD:  lock_period_r = value;
            REG_UNLOCK_PER:   unlock_period_r = value;
            REG_NOKEY_PERIOD: nokey_period_r = value;
            REG_SUC_HOLD:     hold_time_r = value;
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every queued transaction has gone through and its result has arrived.
    // The check runs on the falling edge, once the sender's updates have settled.
    task automatic wait_idle();
        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_status.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return CFG_DATA_W'($urandom_range(0, 4));
        if (pick < 87)
            return 12'hFFF;
        if (pick < 92)
            return 12'h000;
        return CFG_DATA_W'($urandom_range(0, 4095));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_flash();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            return CFG_DATA_W'($urandom_range(1, 5));
        case ($urandom_range(0, 4))
            0:       return 12'h000;
            1:       return 12'h040;
            2:       return 12'h041;
            3:       return 12'hFFF;
            default: return CFG_DATA_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Writes every register with a fresh setting, mostly short times.
    task automatic shuffle_config();
        set_register(REG_FLASH_COUNT, pick_flash());
        set_register(REG_OFF_TIME, pick_time());
        set_register(REG_ON_TIME, pick_time());
        set_register(REG_LOCK_PERIOD, pick_time());
        set_register(REG_UNLOCK_PER, pick_time());
        set_register(REG_NOKEY_PERIOD, pick_time());
        set_register(REG_SUC_HOLD, pick_time());
        if ($urandom_range(0, 3) == 0)
            set_register(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 4095)));
    endtask

    // Mostly a command followed by a run of ticks, with stray ticks and ignored codes mixed in.
    task automatic queue_random_traffic(input int count);
        int         added;
        int         pick;
        int         ticks;
        logic [2:0] code;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                code = 3'($urandom_range(CMD_START, CMD_NOKEY));
                add_command(code, 1'($urandom_range(0, 1)));
                added++;
                ticks = (code == CMD_START) ? $urandom_range(4, 50) : $urandom_range(1, 12);
                repeat (ticks)
                begin
                    add_tick(1'($urandom_range(0, 1)));
                    added++;
                end
            end
            else if (pick < 85)
                add_command(3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)),
                            1'($urandom_range(0, 1)));
            else
            begin
                add_tick(1'($urandom_range(0, 1)));
                added++;
            end
        end
    endtask

    // Sender: offers queued transactions and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_status.push_back(
                    sequencer_step(led_request_t'({s_tuser, s_tdata[2:0], s_tdata[3]})));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    next_req = pending_requests.pop_front();
                    s_tuser <= next_req.kind;
                    s_tdata <= {4'b0000, next_req.system_ready, next_req.command};
                    s_tvalid <= 1'b1;
                    send_gap = gap_length();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (!long_hold_done && seen_results >= 100)
            begin
                long_hold_done = 1'b1;
                hold_cycles = 150;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                hold_cycles = gap_length();
            end
        end
    end

    // Result check against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_results++;
            got_status.green_on = m_tdata[0];
            got_status.red_on = m_tdata[1];
            got_status.sequence_done = m_tdata[2];
            got_status.mode_now = m_tdata[6:3];
            if (expected_status.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("ERROR: result %h arrived with nothing expected", m_tdata);
            end
            else
            begin
                want_status = expected_status.pop_front();
                if (got_status !== want_status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("ERROR: result %0d exp g%b r%b d%b m%0d act g%b r%b d%b m%0d",
                                 seen_results,
                                 want_status.green_on, want_status.red_on,
                                 want_status.sequence_done, want_status.mode_now,
                                 got_status.green_on, got_status.red_on,
                                 got_status.sequence_done, got_status.mode_now);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= IDLE_LIMIT)
            begin
                $display("led_indicator_sequencer_core verification failed");
                $finish;
            end
        end
    end

    // Stimulus: directed checks, register extremes, then random phases.
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Short times so that every mode moves within a few ticks.
        set_register(REG_FLASH_COUNT, 12'd2);
        set_register(REG_OFF_TIME, 12'd1);
        set_register(REG_ON_TIME, 12'd0);
        set_register(REG_LOCK_PERIOD, 12'd0);
        set_register(REG_UNLOCK_PER, 12'd1);
        set_register(REG_NOKEY_PERIOD, 12'd0);
        set_register(REG_SUC_HOLD, 12'd2);
        set_register(REG_UNUSED, 12'hFFF);

        // Idle ignores ready on commands and unknown codes; a ready tick runs the start blinks.
        add_tick(1'b0);
        add_command(CMD_RSVD_LO, 1'b1);
        repeat (8) add_tick(1'b1);
        add_command(CMD_LOCK, 1'b0);
        repeat (2) add_tick(1'b0);
        add_command(CMD_RSVD_HI, 1'b0);
        add_command(CMD_LOCK_SUC, 1'b1);
        repeat (4) add_tick(1'b1);
        add_command(CMD_UNLOCK, 1'b0);
        repeat (3) add_tick(1'b0);
        add_command(CMD_NOKEY, 1'b1);
        repeat (2) add_tick(1'b0);
        add_command(CMD_END, 1'b0);
        add_command(CMD_START, 1'b1);
        add_tick(1'b0);
        wait_idle();

        // Largest times and an out-of-range flash count.
        set_register(REG_FLASH_COUNT, 12'hFFF);
        set_register(REG_OFF_TIME, 12'hFFF);
        set_register(REG_ON_TIME, 12'hFFF);
        set_register(REG_LOCK_PERIOD, 12'hFFF);
        set_register(REG_UNLOCK_PER, 12'hFFF);
        set_register(REG_NOKEY_PERIOD, 12'hFFF);
        set_register(REG_SUC_HOLD, 12'hFFF);
        add_command(CMD_START, 1'b0);
        add_tick(1'b0);
        add_command(CMD_LOCK, 1'b1);
        repeat (2) add_tick(1'b1);
        add_command(CMD_LOCK_SUC, 1'b0);
        repeat (2) add_tick(1'b0);
        add_command(CMD_UNLOCK, 1'b0);
        add_tick(1'b1);
        add_command(CMD_NOKEY, 1'b0);
        repeat (2) add_tick(1'b0);
        wait_idle();

        // Flash count of zero and just above the limit both skip the blinks.
        set_register(REG_FLASH_COUNT, 12'h000);
        add_command(CMD_START, 1'b0);
        add_tick(1'b0);
        wait_idle();
        set_register(REG_FLASH_COUNT, 12'h041);
        add_command(CMD_START, 1'b0);
        add_tick(1'b0);
        wait_idle();

        // Full 64 blinks with zero phase times; upper data bits fall outside the register.
        set_register(REG_FLASH_COUNT, 12'hF40);
        set_register(REG_OFF_TIME, 12'd0);
        set_register(REG_ON_TIME, 12'd0);
        add_command(CMD_START, 1'b0);
        repeat (135) add_tick(1'($urandom_range(0, 1)));
        wait_idle();

        // Random phases, one of them without any idling.
        for (int phase = 0; phase < 6; phase++)
        begin
            no_idling = (phase == 3);
            shuffle_config();
            queue_random_traffic(50);
            wait_idle();
        end
        no_idling = 1'b0;

        repeat (10) @(posedge clk);
        fail_count += expected_status.size();
        if (fail_count == 0)
            $display("led_indicator_sequencer_core verification clean");
        else
            $display("led_indicator_sequencer_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/ledseq_pkg.sv
src/led_indicator_sequencer_core.sv
tb/led_indicator_sequencer_core_test.sv
